/* rtl/rc_pulse_decoder_with_failsafe_assert.svh */
// Assertion macros for the RC pulse decoder checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef RC_PULSE_DECODER_WITH_FAILSAFE_ASSERT_SVH
`define RC_PULSE_DECODER_WITH_FAILSAFE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rcpd_pkg.sv */
// Shared types and constants of the RC pulse decoder with failsafe.
// No dependencies; every other module of the block imports this package.
package rcpd_pkg;

  // Number of capture inputs and decoded channels.
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Depth of the queue between classifier and executor.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [14:0] WIDTH_MAX = 15'h7FFF;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;
  localparam logic [7:0]  BAD_PULSE_LIMIT = 8'd5;

  // Configuration write port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECODE_MODE       = 3'd0,
    REG_PULSE_POLARITY    = 3'd1,
    REG_SYNC_MIN_WIDTH    = 3'd2,
    REG_PPM_CHANNEL_COUNT = 3'd3,
    REG_SCALE_FACTOR      = 3'd4,
    REG_FAILSAFE_CHANNEL  = 3'd5,
    REG_FAILSAFE_MIN      = 3'd6,
    REG_FAILSAFE_MAX      = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_PWM      = 2'd0,
    MODE_PPM_RISE = 2'd1,
    MODE_PPM_EDGE = 2'd2,
    MODE_RSVD     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_BEAT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  // Work handed from the classifier to the executor.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WIDTH = 2'd1,
    OP_BEAT  = 2'd2,
    OP_CLEAR = 2'd3
  } op_kind_e;

  typedef struct packed {
    logic [1:0]  decode_mode;
    logic        pulse_polarity;
    logic [15:0] sync_min_width;
    logic [4:0]  ppm_channel_count;
    logic [2:0]  scale_factor;
    logic [3:0]  failsafe_channel;
    logic [14:0] failsafe_min;
    logic [14:0] failsafe_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] capture_time;
    logic        pin_level;
    logic [3:0]  capture_unit;
  } in_item_t;

  typedef struct packed {
    logic        width_valid;
    logic [3:0]  channel;
    logic [14:0] width;
    logic        link_up;
    logic        radio_lost;
  } out_item_t;

  typedef struct packed {
    op_kind_e    kind;
    logic [3:0]  channel;
    logic [15:0] raw;
  } op_t;

  // Handshake between the queue and its two neighbors.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* rtl/rc_pulse_decoder_with_failsafe.sv */
// RC receiver pulse decoder with radio failsafe, top level.
// Depends on rcpd_pkg, rcpd_front, rcpd_queue and rcpd_back.
//
// The block turns capture-timer edge events into RC channel widths, in
// separate-PWM or one of two PPM frame modes, and gives exactly one result
// for every input transfer, including heartbeat and clear commands, which
// report the radio status. It accepts one item per clock cycle for as long
// as results are taken. The front part classifies an item in the cycle it
// is accepted and writes it to a two-entry queue; the back part scales and
// checks it and loads the result register, so a result passes through a
// queue entry and then the result register before it is offered.
// in_stall_o rises only when that queue is full, which happens once the
// result side has stalled while items keep arriving; the first pop after
// the result stall ends clears it again. Registers are written through the
// plain write port and should change only while no items are in flight.
module rc_pulse_decoder_with_failsafe (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rcpd_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rcpd_pkg::out_item_t             out_data_o
);
  import rcpd_pkg::*;

  cfg_t        cfg_q;
  logic        in_accept;
  op_t         front_op;
  op_t         queue_op;
  queue_ctrl_t qctrl;
  queue_stat_t qstat;
  logic        pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_mode       <= MODE_PWM;
      cfg_q.pulse_polarity    <= 1'b1;
      cfg_q.sync_min_width    <= 16'd3500;
      cfg_q.ppm_channel_count <= 5'd8;
      cfg_q.scale_factor      <= 3'd4;
      cfg_q.failsafe_channel  <= 4'd3;
      cfg_q.failsafe_min      <= 15'd2000;
      cfg_q.failsafe_max      <= 15'd4000;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DECODE_MODE:       cfg_q.decode_mode       <= cfg_data_i[1:0];
        REG_PULSE_POLARITY:    cfg_q.pulse_polarity    <= cfg_data_i[0];
        REG_SYNC_MIN_WIDTH:    cfg_q.sync_min_width    <= cfg_data_i;
        REG_PPM_CHANNEL_COUNT: cfg_q.ppm_channel_count <= cfg_data_i[4:0];
        REG_SCALE_FACTOR:      cfg_q.scale_factor      <= cfg_data_i[2:0];
        REG_FAILSAFE_CHANNEL:  cfg_q.failsafe_channel  <= cfg_data_i[3:0];
        REG_FAILSAFE_MIN:      cfg_q.failsafe_min      <= cfg_data_i[14:0];
        REG_FAILSAFE_MAX:      cfg_q.failsafe_max      <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  // Input transfer happens whenever the queue has room.
  assign in_stall_o  = qstat.full;
  assign in_accept   = in_valid_i && !qstat.full;
  assign qctrl.push  = in_accept;
  assign qctrl.pop   = pop;

  rcpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .op_o     (front_op)
  );

  rcpd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (qctrl),
    .op_i   (front_op),
    .stat_o (qstat),
    .op_o   (queue_op)
  );

  rcpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .qstat_i     (qstat),
    .op_i        (queue_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/rcpd_queue.sv */
// Short queue of classified operations between the front and back parts.
// Depends on rcpd_pkg for the operation type and the queue depth.
module rcpd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcpd_pkg::queue_ctrl_t ctrl_i,
  input  rcpd_pkg::op_t        op_i,
  output rcpd_pkg::queue_stat_t stat_o,
  output rcpd_pkg::op_t        op_o
);
  import rcpd_pkg::*;

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // Pointer and fill count updates.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (ctrl_i.pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (!ctrl_i.push && ctrl_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wptr_q] <= op_i;
    end
  end

  assign op_o         = mem_q[rptr_q];
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

/* rtl/rcpd_front.sv */
// Front part: takes each input transfer, tracks edge timing and frame
// position, and turns the item into an operation. Depends on rcpd_pkg.
module rcpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcpd_pkg::cfg_t    cfg_i,
  input  logic              accept_i,
  input  rcpd_pkg::in_item_t item_i,
  output rcpd_pkg::op_t     op_o
);
  import rcpd_pkg::*;

  logic [15:0] rise_q [NUM_CHANNELS];
  logic [15:0] rise_d [NUM_CHANNELS];
  logic [15:0] last_edge_q, last_edge_d;
  logic [4:0]  frame_cnt_q, frame_cnt_d;

  logic [15:0]         ppm_raw;
  logic                in_frame;
  logic                emit_ok;
  logic                unit_ok;
  logic [3:0]          unit_m1;
  logic [CH_IDX_W-1:0] unit_idx;

  // Frame position and PWM unit decode.
  assign ppm_raw  = item_i.capture_time - last_edge_q;
  assign in_frame = (frame_cnt_q != 5'd0) && (frame_cnt_q <= cfg_i.ppm_channel_count);
  assign emit_ok  = 32'(frame_cnt_q) <= NUM_CHANNELS;
  assign unit_ok  = (item_i.capture_unit != 4'd0) && (32'(item_i.capture_unit) <= NUM_CHANNELS);
  assign unit_m1  = item_i.capture_unit - 4'd1;
  assign unit_idx = unit_m1[CH_IDX_W-1:0];

  // Classification and next timing state.
  always_comb begin
    rise_d       = rise_q;
    last_edge_d  = last_edge_q;
    frame_cnt_d  = frame_cnt_q;
    op_o.kind    = OP_NONE;
    op_o.channel = 4'd0;
    op_o.raw     = 16'd0;
    unique case (cmd_e'(item_i.cmd))
      CMD_EDGE: begin
        unique case (mode_e'(cfg_i.decode_mode))
          MODE_PWM: begin
            if (unit_ok) begin
              if (item_i.pin_level) begin
                rise_d[unit_idx] = item_i.capture_time;
              end else begin
                op_o.kind    = OP_WIDTH;
                op_o.channel = item_i.capture_unit;
                op_o.raw     = item_i.capture_time - rise_q[unit_idx];
              end
            end
          end
          MODE_PPM_RISE: begin
            if (item_i.pin_level == cfg_i.pulse_polarity) begin
              last_edge_d = item_i.capture_time;
              if (ppm_raw > cfg_i.sync_min_width) begin
                frame_cnt_d = 5'd1;
              end else if (in_frame) begin
                frame_cnt_d = frame_cnt_q + 5'd1;
                if (emit_ok) begin
                  op_o.kind    = OP_WIDTH;
                  op_o.channel = frame_cnt_q[3:0];
                  op_o.raw     = ppm_raw;
                end
              end
            end
          end
          MODE_PPM_EDGE: begin
            last_edge_d = item_i.capture_time;
            if (item_i.pin_level == cfg_i.pulse_polarity) begin
              if (ppm_raw > cfg_i.sync_min_width) begin
                frame_cnt_d = 5'd1;
              end
            end else if (in_frame) begin
              frame_cnt_d = frame_cnt_q + 5'd1;
              if (emit_ok) begin
                op_o.kind    = OP_WIDTH;
                op_o.channel = frame_cnt_q[3:0];
                op_o.raw     = ppm_raw;
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_BEAT:  op_o.kind = OP_BEAT;
      CMD_CLEAR: op_o.kind = OP_CLEAR;
      default: begin
      end
    endcase
  end

  // Timing state only moves on an accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_q[i] <= '0;
      end
      last_edge_q <= '0;
      frame_cnt_q <= '0;
    end else if (accept_i) begin
      rise_q      <= rise_d;
      last_edge_q <= last_edge_d;
      frame_cnt_q <= frame_cnt_d;
    end
  end

endmodule

/* rtl/rcpd_back.sv */
// Back part: scales widths, keeps the failsafe counters and radio status,
// and holds the result register. Depends on rcpd_pkg.
module rcpd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcpd_pkg::cfg_t     cfg_i,
  input  rcpd_pkg::queue_stat_t qstat_i,
  input  rcpd_pkg::op_t      op_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rcpd_pkg::out_item_t out_data_o
);
  import rcpd_pkg::*;

  logic [7:0] good_q, good_d;
  logic [7:0] bad_q, bad_d;
  logic       radio_q, radio_d;
  logic       out_valid_q;
  out_item_t  out_q, out_d;

  logic [18:0] product;
  logic [17:0] scaled;
  logic [14:0] width_sat;
  logic        width_good;
  logic        fs_match;

  // Take the next operation whenever the result register is free or drains.
  assign pop_o = !qstat_i.empty && (!out_valid_q || !out_stall_i);

  // Width scaling and failsafe window check.
  assign product    = 19'(op_i.raw) * 19'(cfg_i.scale_factor);
  assign scaled     = product[18:1];
  assign width_sat  = (scaled > 18'(WIDTH_MAX)) ? WIDTH_MAX : scaled[14:0];
  assign width_good = (width_sat > cfg_i.failsafe_min) && (width_sat < cfg_i.failsafe_max);
  assign fs_match   = (op_i.channel == cfg_i.failsafe_channel);

  // Counter, status and result update for one operation.
  always_comb begin
    good_d = good_q;
    bad_d  = bad_q;
    radio_d = radio_q;
    out_d.width_valid = 1'b0;
    out_d.channel     = 4'd0;
    out_d.width       = 15'd0;
    out_d.radio_lost  = 1'b0;
    unique case (op_i.kind)
      OP_WIDTH: begin
        out_d.width_valid = 1'b1;
        out_d.channel     = op_i.channel;
        out_d.width       = width_sat;
        if (fs_match) begin
          if (width_good) begin
            if (good_q != COUNT_MAX) good_d = good_q + 8'd1;
          end else begin
            if (bad_q != COUNT_MAX) bad_d = bad_q + 8'd1;
          end
        end
      end
      OP_BEAT: begin
        if ((good_q == 8'd0) || (bad_q > BAD_PULSE_LIMIT)) begin
          out_d.radio_lost = radio_q;
          radio_d = 1'b0;
          bad_d   = 8'd0;
        end else begin
          radio_d = 1'b1;
        end
        good_d = 8'd0;
      end
      OP_CLEAR: bad_d = 8'd0;
      default: begin
      end
    endcase
    out_d.link_up = radio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q      <= '0;
      bad_q       <= '0;
      radio_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        good_q  <= good_d;
        bad_q   <= bad_d;
        radio_q <= radio_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload holds while stalled.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/rcpd_checker.sv */
// Port-level checker for the RC pulse decoder, bound to the top level.
// Depends on rcpd_pkg and the assertion macro header.
`include "rc_pulse_decoder_with_failsafe_assert.svh"

module rcpd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input rcpd_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rcpd_pkg::out_item_t out_data_o
);
  import rcpd_pkg::*;

  // A stalled input transfer must stay offered and unchanged.
  `RCPD_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(in_data_i), "stalled input changed")

  // A stalled result must stay offered and unchanged.
  `RCPD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")

  // Results without a width carry no channel and no width.
  `RCPD_ASSERT_SAME(a_no_width_zero, out_valid_o && !out_data_o.width_valid,
    (out_data_o.channel == 4'd0) && (out_data_o.width == 15'd0),
    "non-width result has channel or width")

  // A width always names a real channel.
  `RCPD_ASSERT_SAME(a_width_channel, out_valid_o && out_data_o.width_valid,
    (out_data_o.channel != 4'd0) && (32'(out_data_o.channel) <= NUM_CHANNELS),
    "width on invalid channel")

  // Losing the radio leaves it off and comes only from a heartbeat.
  `RCPD_ASSERT_SAME(a_lost_off, out_valid_o && out_data_o.radio_lost,
    !out_data_o.link_up && !out_data_o.width_valid, "radio lost while on or with width")

endmodule

bind rc_pulse_decoder_with_failsafe rcpd_checker u_rcpd_checker (.*);

/* bench/rc_pulse_decoder_with_failsafe_tb.sv */
// Testbench for the RC pulse decoder with failsafe.
// Depends on rcpd_pkg and rc_pulse_decoder_with_failsafe. It drives capture events and
// commands in every decode mode and checks each result against an in-bench decoder.
`timescale 1ns / 1ps

module rc_pulse_decoder_with_failsafe_tb;
  import rcpd_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;

  // Register copy and decoder state of the in-bench decoder.
  cfg_t        cfg_now;
  logic [15:0] rise_at [NUM_CHANNELS];
  logic [15:0] last_edge;
  logic [4:0]  frame_slot;
  logic [7:0]  good_pulses;
  logic [7:0]  bad_pulses;
  logic        radio_up;

  // Decoded results still owed by the block, oldest first.
  out_item_t pending_decodes[$];

  logic [15:0] tick_now;
  int          burst_left = 0;
  int          stall_left = 0;
  int          free_left  = 0;
  bit          rx_steady  = 1'b0;
  int          errors     = 0;
  int          items_sent = 0;
  int          widths_seen = 0;
  int          losses_seen = 0;

  rc_pulse_decoder_with_failsafe dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Decode one accepted item: update the decoder state and return its result.
  function automatic out_item_t decode_capture(input in_item_t it);
    out_item_t   r;
    logic [15:0] raw;
    logic        emit;
    logic [3:0]  emit_ch;
    logic [15:0] emit_raw;
    logic [31:0] scaled;
    logic        lost;
    r = '0;
    emit = 1'b0;
    emit_ch = '0;
    emit_raw = '0;
    lost = 1'b0;
    raw = it.capture_time - last_edge;
    case (cmd_e'(it.cmd))
      CMD_EDGE: begin
        case (mode_e'(cfg_now.decode_mode)) inside
          MODE_PWM: begin
            if (it.capture_unit >= 1 && it.capture_unit <= NUM_CHANNELS) begin
              if (it.pin_level) begin
                rise_at[it.capture_unit - 1] = it.capture_time;
              end else begin
                emit = 1'b1;
                emit_ch = it.capture_unit;
                emit_raw = it.capture_time - rise_at[it.capture_unit - 1];
              end
            end
          end
          MODE_PPM_RISE, MODE_PPM_EDGE: begin
            // Rising mode only sees pulse edges; edge mode times every edge.
            if (cfg_now.decode_mode == MODE_PPM_EDGE || it.pin_level == cfg_now.pulse_polarity)
              last_edge = it.capture_time;
            if (it.pin_level == cfg_now.pulse_polarity && raw > cfg_now.sync_min_width) begin
              frame_slot = 5'd1;
            end else if ((cfg_now.decode_mode == MODE_PPM_RISE) ==
                         (it.pin_level == cfg_now.pulse_polarity)) begin
              // A channel interval counts only inside a frame.
              if (frame_slot != 0 && frame_slot <= cfg_now.ppm_channel_count) begin
                if (frame_slot <= NUM_CHANNELS) begin
                  emit = 1'b1;
                  emit_ch = frame_slot[3:0];
                  emit_raw = raw;
                end
                frame_slot = frame_slot + 5'd1;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_BEAT: begin
        if (good_pulses == 0 || bad_pulses > BAD_PULSE_LIMIT) begin
          if (radio_up) begin
            radio_up = 1'b0;
            lost = 1'b1;
          end
          bad_pulses = '0;
        end else begin
          radio_up = 1'b1;
        end
        good_pulses = '0;
      end
      CMD_CLEAR: bad_pulses = '0;
      default: ;
    endcase

    // Scale the width, saturate it and grade it on the failsafe channel.
    if (emit) begin
      scaled = ({16'd0, emit_raw} * {29'd0, cfg_now.scale_factor}) >> 1;
      r.width_valid = 1'b1;
      r.channel = emit_ch;
      r.width = (scaled > 32'(WIDTH_MAX)) ? WIDTH_MAX : scaled[14:0];
      if (emit_ch == cfg_now.failsafe_channel) begin
        if (r.width > cfg_now.failsafe_min && r.width < cfg_now.failsafe_max) begin
          if (good_pulses != COUNT_MAX) good_pulses++;
        end else begin
          if (bad_pulses != COUNT_MAX) bad_pulses++;
        end
      end
    end
    r.link_up = radio_up;
    r.radio_lost = lost;
    return r;
  endfunction

  // Send one item in bursts with random gaps, then record what it should decode to.
  task automatic send_capture(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_decodes.push_back(decode_capture(it));
    items_sent++;
  endtask

  function automatic in_item_t edge_at(input logic [15:0] t, input logic pin,
                                       input logic [3:0] unit);
    in_item_t it;
    it.cmd = CMD_EDGE;
    it.capture_time = t;
    it.pin_level = pin;
    it.capture_unit = unit;
    return it;
  endfunction

  task automatic send_edge(input int unsigned delta, input logic pin, input logic [3:0] unit);
    tick_now += 16'(delta);
    send_capture(edge_at(tick_now, pin, unit));
  endtask

  // Commands carry random junk in the fields they do not use.
  task automatic send_command(input cmd_e c);
    in_item_t it;
    it.cmd = c;
    it.capture_time = 16'($urandom);
    it.pin_level = 1'($urandom);
    it.capture_unit = 4'($urandom);
    send_capture(it);
  endtask

  task automatic mix_in_commands();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) send_command(CMD_BEAT);
    else if (r < 13) send_command(CMD_CLEAR);
    else if (r < 15) send_command(CMD_RSVD);
  endtask

  // Raw interval, mostly one that scales into the failsafe window.
  function automatic logic [15:0] pick_raw();
    int unsigned target;
    int unsigned f;
    f = cfg_now.scale_factor;
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom);
      default: ;
    endcase
    if (f == 0 || f > 4 || cfg_now.failsafe_max <= cfg_now.failsafe_min + 1)
      return 16'($urandom_range(0, 3000));
    target = $urandom_range(cfg_now.failsafe_min + 1, cfg_now.failsafe_max - 1);
    return 16'((target * 2 + f - 1) / f);
  endfunction

  function automatic cfg_t random_settings(input mode_e m);
    cfg_t c;
    c.decode_mode = m;
    c.pulse_polarity = 1'($urandom);
    c.sync_min_width = 16'($urandom_range(2500, 6000));
    c.ppm_channel_count = 5'($urandom_range(1, 10));
    c.scale_factor = 3'($urandom_range(1, 4));
    c.failsafe_channel = 4'($urandom_range(1, NUM_CHANNELS));
    c.failsafe_min = 15'($urandom_range(800, 2500));
    c.failsafe_max = 15'($urandom_range(3000, 6000));
    return c;
  endfunction

  // Write all registers, with junk above the width of each register narrower than the port.
  task automatic apply_settings(input cfg_t c);
    logic [15:0] val;
    int unsigned fw;
    reg_idx_e    r;
    for (int i = 0; i < 8; i++) begin
      r = reg_idx_e'(i);
      case (r)
        REG_DECODE_MODE:       begin val = 16'(c.decode_mode);       fw = 2;  end
        REG_PULSE_POLARITY:    begin val = 16'(c.pulse_polarity);    fw = 1;  end
        REG_SYNC_MIN_WIDTH:    begin val = c.sync_min_width;         fw = 16; end
        REG_PPM_CHANNEL_COUNT: begin val = 16'(c.ppm_channel_count); fw = 5;  end
        REG_SCALE_FACTOR:      begin val = 16'(c.scale_factor);      fw = 3;  end
        REG_FAILSAFE_CHANNEL:  begin val = 16'(c.failsafe_channel);  fw = 4;  end
        REG_FAILSAFE_MIN:      begin val = 16'(c.failsafe_min);      fw = 15; end
        default:               begin val = 16'(c.failsafe_max);      fw = 15; end
      endcase
      if (fw < 16) val = val | (16'($urandom) << fw);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_now = c;
    @(posedge clk_i);
  endtask

  // Stop sending, wait for every owed result and report any that never arrive.
  task automatic settle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_decodes.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_decodes.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_decodes.size());
      pending_decodes.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Rise and fall pairs, biased toward the failsafe channel.
  task automatic pwm_traffic(input int pulses);
    logic [3:0] unit;
    repeat (pulses) begin
      case ($urandom_range(0, 9))
        0:          unit = 4'($urandom);
        1, 2, 3, 4: unit = cfg_now.failsafe_channel;
        default:    unit = 4'($urandom_range(1, NUM_CHANNELS));
      endcase
      if ($urandom_range(0, 11) != 0) send_edge($urandom_range(0, 20000), 1'b1, unit);
      send_edge(pick_raw(), 1'b0, unit);
      mix_in_commands();
    end
  endtask

  // PPM frames: a sync interval, then the channel count of slots plus up to two more.
  task automatic ppm_frames(input int frames);
    logic        pol;
    int          slots;
    int unsigned gap;
    logic [15:0] raw;
    pol = cfg_now.pulse_polarity;
    repeat (frames) begin
      send_edge(cfg_now.sync_min_width + $urandom_range(1, 3000), pol, 4'($urandom));
      slots = cfg_now.ppm_channel_count + $urandom_range(0, 2);
      repeat (slots) begin
        raw = pick_raw();
        if (raw > cfg_now.sync_min_width && $urandom_range(0, 7) != 0)
          raw = 16'($urandom_range(0, cfg_now.sync_min_width));
        if (cfg_now.decode_mode == MODE_PPM_EDGE) begin
          // Width is timed to the trailing edge; the short gap must not resync.
          send_edge(raw, !pol, 4'($urandom));
          gap = $urandom_range(0, 600);
          if (gap > cfg_now.sync_min_width) gap = cfg_now.sync_min_width;
          send_edge(gap, pol, 4'($urandom));
        end else begin
          if ($urandom_range(0, 7) == 0) send_edge($urandom_range(0, 300), !pol, 4'($urandom));
          send_edge(raw, pol, 4'($urandom));
        end
        mix_in_commands();
      end
      if ($urandom_range(0, 1) != 0) send_command(CMD_BEAT);
    end
  endtask

  // Reset settings: widths at and across the failsafe bounds, ignored units,
  // wrap of the timer, saturation, and the radio going on and then lost.
  task automatic test_pwm_directed();
    send_command(CMD_BEAT);
    send_capture(edge_at(16'h0000, 1'b1, 4'd3));
    send_capture(edge_at(16'h05DC, 1'b0, 4'd3));
    send_capture(edge_at(16'hFFFF, 1'b1, 4'd1));
    send_capture(edge_at(16'h0010, 1'b0, 4'd1));
    send_capture(edge_at(16'hFFFF, 1'b0, 4'd8));
    send_capture(edge_at(16'h1234, 1'b0, 4'd0));
    send_capture(edge_at(16'h2345, 1'b1, 4'd9));
    send_capture(edge_at(16'hABCD, 1'b0, 4'd15));
    send_command(CMD_RSVD);
    send_command(CMD_BEAT);
    send_command(CMD_CLEAR);
    send_capture(edge_at(16'h03E8, 1'b0, 4'd3));
    send_capture(edge_at(16'h07D0, 1'b0, 4'd3));
    for (int i = 0; i < 4; i++) send_capture(edge_at(16'h0100 + 16'(i), 1'b0, 4'd3));
    send_capture(edge_at(16'h05DC, 1'b0, 4'd3));
    send_command(CMD_BEAT);
    send_command(CMD_BEAT);
    settle();
  endtask

  task automatic test_pwm_random();
    rx_steady = 1'b0;
    apply_settings(random_settings(MODE_PWM));
    pwm_traffic(30);
    settle();
  endtask

  task automatic test_ppm_rising();
    cfg_t c;
    for (int pol = 1; pol >= 0; pol--) begin
      rx_steady = (pol == 1);
      c = random_settings(MODE_PPM_RISE);
      c.pulse_polarity = 1'(pol);
      apply_settings(c);
      ppm_frames(4);
      settle();
    end
    rx_steady = 1'b0;
  endtask

  task automatic test_ppm_edge_to_edge();
    cfg_t c;
    for (int pol = 0; pol <= 1; pol++) begin
      c = random_settings(MODE_PPM_EDGE);
      c.pulse_polarity = 1'(pol);
      apply_settings(c);
      ppm_frames(3);
      settle();
    end
  endtask

  // Register extremes and values outside the intended ranges.
  task automatic test_unusual_settings();
    cfg_t c;
    for (int v = 0; v < 8; v++) begin
      case (v)
        0: c = random_settings(MODE_RSVD);
        1: begin
          c = random_settings(MODE_PPM_RISE);
          c.ppm_channel_count = 5'd0;
        end
        2: begin
          // Enough slots to walk the frame counter past its top and wrap it.
          c = random_settings(MODE_PPM_RISE);
          c.ppm_channel_count = 5'd31;
        end
        3: begin
          c = random_settings(MODE_PPM_RISE);
          c.ppm_channel_count = 5'd12;
          c.scale_factor = 3'd7;
          c.failsafe_channel = 4'd15;
          c.failsafe_min = 15'd0;
          c.failsafe_max = 15'h7FFF;
        end
        4: begin
          c = random_settings(MODE_PWM);
          c.scale_factor = 3'd0;
          c.failsafe_channel = 4'd9;
          c.failsafe_min = 15'h7FFF;
          c.failsafe_max = 15'd0;
        end
        5: begin
          c = random_settings(MODE_PWM);
          c.scale_factor = 3'd5;
          c.failsafe_channel = 4'(NUM_CHANNELS);
          c.failsafe_min = 15'd0;
          c.failsafe_max = 15'h7FFF;
        end
        6: begin
          c = random_settings(MODE_PPM_EDGE);
          c.sync_min_width = 16'd0;
          c.failsafe_channel = 4'd0;
          c.pulse_polarity = 1'b0;
        end
        default: begin
          c = random_settings(MODE_PPM_RISE);
          c.sync_min_width = 16'hFFFF;
          c.scale_factor = 3'd6;
        end
      endcase
      apply_settings(c);
      if (c.decode_mode == MODE_PWM || c.decode_mode == MODE_RSVD) pwm_traffic(4);
      ppm_frames((c.ppm_channel_count > 16) ? 1 : 2);
      settle();
    end
  endtask

  // Check each result transfer against the oldest decode and stall on a pattern.
  always @(posedge clk_i) begin : check_result
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("result with nothing owed", out_data_o, 0);
        end else begin
          want = pending_decodes.pop_front();
          if (out_data_o.width_valid !== want.width_valid)
            report_mismatch("width_valid", out_data_o.width_valid, want.width_valid);
          if (out_data_o.channel !== want.channel)
            report_mismatch("channel", out_data_o.channel, want.channel);
          if (out_data_o.width !== want.width)
            report_mismatch("width", out_data_o.width, want.width);
          if (out_data_o.link_up !== want.link_up)
            report_mismatch("link_up", out_data_o.link_up, want.link_up);
          if (out_data_o.radio_lost !== want.radio_lost)
            report_mismatch("radio_lost", out_data_o.radio_lost, want.radio_lost);
          if (want.width_valid) widths_seen++;
          if (want.radio_lost) losses_seen++;
        end
      end
      if (stall_left == 0 && free_left == 0) begin
        stall_left = $urandom_range(0, 5);
        free_left  = $urandom_range(1, 8);
      end
      if (rx_steady || stall_left == 0) begin
        out_stall_i <= 1'b0;
        if (free_left > 0) free_left--;
      end else begin
        out_stall_i <= 1'b1;
        stall_left--;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_DECODE_MODE;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_now = '{decode_mode: MODE_PWM, pulse_polarity: 1'b1, sync_min_width: 16'd3500,
                ppm_channel_count: 5'd8, scale_factor: 3'd4, failsafe_channel: 4'd3,
                failsafe_min: 15'd2000, failsafe_max: 15'd4000};
    foreach (rise_at[k]) rise_at[k] = '0;
    last_edge   = '0;
    frame_slot  = '0;
    good_pulses = '0;
    bad_pulses  = '0;
    radio_up    = 1'b0;
    tick_now    = 16'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pwm_directed();
    test_pwm_random();
    test_ppm_rising();
    test_ppm_edge_to_edge();
    test_unusual_settings();
    settle();

    $display("summary: %0d items in PWM, both PPM modes and edge-case settings", items_sent);
    $display("summary: %0d widths and %0d radio losses checked, %0d mismatches",
             widths_seen, losses_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
